>>> rtl/path_key_validator_core_macros.svh
// Assertion macros for the path key validator core.
// Included by the top level; no other dependencies.
`ifndef PATH_KEY_VALIDATOR_CORE_MACROS_SVH
`define PATH_KEY_VALIDATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled during reset.
`define PKV_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pkv assertion failed");
// Next-cycle implication, sampled on clk and disabled during reset.
`define PKV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pkv assertion failed");
`else
`define PKV_ASSERT_NOW(label, ante, cons)
`define PKV_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/pkv_pkg.sv
// Shared types and constants of the path key validator.
// No dependencies.
package pkv_pkg;

    // Characters with a special meaning in a key.
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_NUL    = 8'h00;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_SUFFIX_BYTES  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SUFFIX_LENGTH = 1'b1;

    // What the current component looks like so far.
    typedef enum logic [1:0] {
        DOT_NONE,
        DOT_ONE,
        DOT_TWO,
        DOT_OTHER
    } dot_t;

    // One key character request as held in the input stage.
    typedef struct packed {
        logic [7:0] key_byte;
        logic       key_last;
        logic       key_empty;
    } item_t;

    // Outcome of processing one request.
    typedef struct packed {
        logic has_result;
        logic ok;
    } scan_result_t;

endpackage

>>> rtl/pkv_in_reg.sv
// Input register stage of the path key validator.
// Depends on pkv_pkg.
module pkv_in_reg
    import pkv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  key_valid,
    output logic  key_ready,
    input  item_t item_in,
    input  logic  take,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The stage accepts a new request when empty or when its request moves on.
    assign key_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (key_valid && key_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (key_valid && key_ready)
        begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> rtl/pkv_scan.sv
// Key scanning state and per-character rule checks.
// Depends on pkv_pkg.
module pkv_scan
    import pkv_pkg::*;
#(
    parameter int MAX_SUFFIX = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  item_t        item,
    input  logic         step,
    input  logic [63:0]  suffix_bytes,
    input  logic [3:0]   suffix_length,
    output scan_result_t res
);

    localparam int LEN_W = $clog2(MAX_SUFFIX + 1);
    localparam int REC_W = 8 * MAX_SUFFIX;

    logic             still_valid_reg;
    logic             still_valid_next;
    logic             at_start_reg;
    logic             at_start_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    dot_t             dot_reg;
    dot_t             dot_next;
    logic [REC_W-1:0] rec_reg;
    logic [REC_W-1:0] rec_next;

    logic [LEN_W-1:0] sfx_n;
    logic [REC_W-1:0] sfx_lo;
    logic             is_sep;
    logic             valid_work;

    // A component is bad if it is empty, "." or "..", or ends in the suffix.
    function automatic logic comp_bad(
        input logic [LEN_W-1:0] len,
        input dot_t             dot,
        input logic [REC_W-1:0] rec,
        input logic [LEN_W-1:0] n,
        input logic [REC_W-1:0] sfx
    );
        logic match;
        begin
            match = 1'b1;
            for (int i = 0; i < MAX_SUFFIX; i++)
            begin
                if ((LEN_W'(i) < n) && (rec[8*i +: 8] != sfx[8*i +: 8]))
                begin
                    match = 1'b0;
                end
            end
            if (dot != DOT_OTHER)
            begin
                comp_bad = 1'b1;
            end
            else if ((n == '0) || (len < n))
            begin
                comp_bad = 1'b0;
            end
            else
            begin
                comp_bad = match;
            end
        end
    endfunction

    // Suffix length above the supported maximum is clamped.
    always_comb
    begin
        if (suffix_length > 4'(MAX_SUFFIX))
        begin
            sfx_n = LEN_W'(MAX_SUFFIX);
        end
        else
        begin
            sfx_n = LEN_W'(suffix_length);
        end
    end

    assign sfx_lo = suffix_bytes[REC_W-1:0];
    assign is_sep = (item.key_byte == CHAR_SLASH) || (item.key_byte == CHAR_BSLASH);

    // Next state and verdict for the request in the input stage.
    always_comb
    begin
        still_valid_next = still_valid_reg;
        at_start_next    = at_start_reg;
        len_next         = len_reg;
        dot_next         = dot_reg;
        rec_next         = rec_reg;
        valid_work       = still_valid_reg;
        res.has_result   = 1'b0;
        res.ok           = 1'b0;

        if (item.key_empty)
        begin
            res.has_result   = 1'b1;
            res.ok           = 1'b0;
            still_valid_next = 1'b1;
            at_start_next    = 1'b1;
            len_next         = '0;
            dot_next         = DOT_NONE;
            rec_next         = '0;
        end
        else
        begin
            if (item.key_byte == CHAR_NUL)
            begin
                valid_work = 1'b0;
            end

            if (is_sep)
            begin
                // The one leading separator is skipped; any other ends a component.
                if (!at_start_reg)
                begin
                    if (comp_bad(len_reg, dot_reg, rec_reg, sfx_n, sfx_lo))
                    begin
                        valid_work = 1'b0;
                    end
                    len_next = '0;
                    dot_next = DOT_NONE;
                    rec_next = '0;
                end
            end
            else
            begin
                if (len_reg < LEN_W'(MAX_SUFFIX))
                begin
                    len_next = len_reg + LEN_W'(1);
                end
                case (dot_reg)
                    DOT_NONE: dot_next = (item.key_byte == CHAR_DOT) ? DOT_ONE : DOT_OTHER;
                    DOT_ONE:  dot_next = (item.key_byte == CHAR_DOT) ? DOT_TWO : DOT_OTHER;
                    default:  dot_next = DOT_OTHER;
                endcase
                rec_next = (rec_reg << 8) | REC_W'(item.key_byte);
            end
            at_start_next    = 1'b0;
            still_valid_next = valid_work;

            // Final character: check the last component and clear for the next key.
            if (item.key_last)
            begin
                res.has_result = 1'b1;
                res.ok = valid_work && !is_sep &&
                         !comp_bad(len_next, dot_next, rec_next, sfx_n, sfx_lo);
                still_valid_next = 1'b1;
                at_start_next    = 1'b1;
                len_next         = '0;
                dot_next         = DOT_NONE;
                rec_next         = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            still_valid_reg <= 1'b1;
            at_start_reg    <= 1'b1;
            len_reg         <= '0;
            dot_reg         <= DOT_NONE;
            rec_reg         <= '0;
        end
        else if (step)
        begin
            still_valid_reg <= still_valid_next;
            at_start_reg    <= at_start_next;
            len_reg         <= len_next;
            dot_reg         <= dot_next;
            rec_reg         <= rec_next;
        end
    end

endmodule

>>> rtl/pkv_out_reg.sv
// Result register of the path key validator.
// No dependencies.
module pkv_out_reg
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  logic ok_in,
    output logic result_valid,
    input  logic result_ready,
    output logic key_ok
);

    logic valid_reg;
    logic valid_next;
    logic ok_reg;

    // A new verdict replaces the one taken in the same cycle.
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ok_reg <= ok_in;
        end
    end

    assign result_valid = valid_reg;
    assign key_ok       = ok_reg;

endmodule

>>> rtl/path_key_validator_core.sv
// Top level of the path key validator core.
// Depends on pkv_pkg, pkv_in_reg, pkv_scan, pkv_out_reg and the macros header.
//
// Usage:
//   A key streams in one character per request on the key channel
//   (key_valid/key_ready with key_byte, key_last, key_empty). The request
//   with key_last set, or any request with key_empty set, produces one
//   verdict on the result channel (result_valid/result_ready with key_ok).
//   Other requests produce nothing.
//   The lock suffix is set through cfg_we/cfg_index/cfg_data while no key
//   is in flight: index 0 holds the suffix bytes, index 1 the length.
//   Throughput is one character per cycle while no verdict is blocked; the
//   rule checks of a character are combinational logic between the input
//   register and the result register. The verdict of a final character is
//   computed from the input register and loaded into the result register.
//   When the receiver stalls, the verdict holds in the result register and
//   characters that produce no verdict keep flowing; a second verdict waits
//   in the input register, and the key channel then stalls.
//   Reset clears the pipeline, the key state and the suffix registers.
`include "path_key_validator_core_macros.svh"
module path_key_validator_core
    import pkv_pkg::*;
#(
    parameter int MAX_SUFFIX = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   key_valid,
    output logic                   key_ready,
    input  logic [7:0]             key_byte,
    input  logic                   key_last,
    input  logic                   key_empty,
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic                   key_ok,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data
);

    logic [63:0]  suffix_bytes_reg;
    logic [3:0]   suffix_length_reg;
    item_t        item_in;
    item_t        item;
    logic         item_valid;
    logic         advance;
    logic         verdict_blocked;
    scan_result_t scan_res;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            suffix_bytes_reg  <= '0;
            suffix_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SUFFIX_BYTES:  suffix_bytes_reg  <= cfg_data;
                REG_SUFFIX_LENGTH: suffix_length_reg <= cfg_data[3:0];
                default:           ;
            endcase
        end
    end

    assign item_in.key_byte  = key_byte;
    assign item_in.key_last  = key_last;
    assign item_in.key_empty = key_empty;

    // A request moves on unless it has a verdict and the result register is blocked.
    assign verdict_blocked = result_valid && !result_ready && scan_res.has_result;
    assign advance         = item_valid && !verdict_blocked;

    pkv_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_valid  (key_valid),
        .key_ready  (key_ready),
        .item_in    (item_in),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    pkv_scan #(
        .MAX_SUFFIX (MAX_SUFFIX)
    ) u_scan
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .step          (advance),
        .suffix_bytes  (suffix_bytes_reg),
        .suffix_length (suffix_length_reg),
        .res           (scan_res)
    );

    pkv_out_reg u_out_reg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && scan_res.has_result),
        .ok_in        (scan_res.ok),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .key_ok       (key_ok)
    );

    // The key channel stalls only behind a blocked verdict.
    `PKV_ASSERT_NOW(a_stall_cause, item_valid && !key_ready, verdict_blocked)
    // A verdict that leaves the scanner lands in the result register.
    `PKV_ASSERT_NEXT(a_verdict_lands, advance && scan_res.has_result, result_valid)
    // An empty key always yields a failing verdict.
    `PKV_ASSERT_NEXT(a_empty_fails, advance && item.key_empty, result_valid && !key_ok)

endmodule
